/* sv/spherical_range_image_projection_assert.svh */
// ----------------------------------------------------------------------------
// Spherical range image projection assertion macros
// Shared property forms for the concurrent checks of the projection block.
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_RANGE_IMAGE_PROJECTION_ASSERT_SVH
`define SPHERICAL_RANGE_IMAGE_PROJECTION_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define SRIP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the trigger.
`define SRIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/srip_pkg.sv */
// ----------------------------------------------------------------------------
// Spherical range image projection package
// Sizes, request and result types and the CORDIC angle table.
// ----------------------------------------------------------------------------
`default_nettype none

package srip_pkg;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 256;
  localparam int COORD_BITS   = 20;
  localparam int CORDIC_STEPS = 20;
  localparam int FRAC_BITS    = (2 * COORD_BITS >= 64) ? 0 :
                                (((64 - 2 * COORD_BITS) < 10) ? (64 - 2 * COORD_BITS) : 10);

  localparam int COL_W   = $clog2(MAX_COLS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int ADDR_W  = COL_W + ROW_W;
  localparam int COLS_W  = $clog2(MAX_COLS + 1);
  localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
  localparam int RANGE_W = 20;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 1;
  localparam int SUM_W   = 2 * COORD_BITS;
  localparam int RAD_W   = SUM_W + FRAC_BITS + ((SUM_W + FRAC_BITS) % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int CW      = COORD_BITS + FRAC_BITS + 4;
  localparam int ANG_W   = 32;
  localparam int IT_W    = $clog2(CORDIC_STEPS + 1);
  localparam logic [RANGE_W-1:0] RANGE_MAX = '1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 1'b1;

  // One queued request
  typedef struct packed {
    logic                         cmd;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic [COL_W-1:0]             rcol;
    logic [ROW_W-1:0]             rrow;
  } srip_item_t;

  // One result
  typedef struct packed {
    logic [RANGE_W-1:0] pixel_range;
    logic               skipped;
    logic               newly_filled;
    logic               stored;
    logic [RANGE_W-1:0] range_mm;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
  } srip_res_t;

  // atan(2^-k) as a fraction of a turn, 2^32 is one turn
  function automatic logic [ANG_W-1:0] turn_atan(input logic [4:0] k);
    logic [ANG_W-1:0] a;
    unique case (k)
      5'd0:  a = 32'h20000000;  5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;  5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;  5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;  5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;  5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;  5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;  5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;  5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;  5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;  5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;  5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;  5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;  5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;  5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;  5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;  5'd31: a = 32'h00000000;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* sv/srip_front.sv */
// ----------------------------------------------------------------------------
// Request queue
// Accepts requests from the input stream into a two-entry queue for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module srip_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               hold_i,
  input  wire logic               in_vld_i,
  output logic                    in_rdy_o,
  input  wire srip_pkg::srip_item_t in_item_i,
  output logic                    q_vld_o,
  output srip_pkg::srip_item_t    q_item_o,
  input  wire logic               q_pop_i
);
  import srip_pkg::*;

  srip_item_t slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  // No request is taken while the store is being cleared.
  assign in_rdy_o = (cnt_q != 2'd2) && !hold_i;
  assign push     = in_vld_i && in_rdy_o;
  assign q_vld_o  = (cnt_q != 2'd0);
  assign q_item_o = slot_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= !rd_ptr_q;
      if (push && !q_pop_i) cnt_q <= cnt_q + 2'd1;
      else if (!push && q_pop_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  // Payload slots
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= in_item_i;
  end

endmodule

`default_nettype wire

/* sv/srip_sqrt.sv */
// ----------------------------------------------------------------------------
// Iterative square root
// Floor square root and remainder, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srip_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [srip_pkg::RAD_W-1:0] rad_i,
  output logic                            vld_o,
  output logic [srip_pkg::ROOT_W-1:0]     root_o,
  output logic [srip_pkg::ROOT_W:0]       rem_o
);
  import srip_pkg::*;

  logic [RAD_W-1:0] s_q, r_q, bit_q;
  logic             busy_q, vld_q;
  logic [RAD_W:0]   trial;

  assign trial  = {1'b0, r_q} + {1'b0, bit_q};
  assign vld_o  = vld_q;
  assign root_o = r_q[ROOT_W-1:0];
  assign rem_o  = s_q[ROOT_W:0];

  // One trial subtraction per cycle, the bit walks down two places each time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
      s_q    <= '0;
      r_q    <= '0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      vld_q  <= 1'b0;
      s_q    <= rad_i;
      r_q    <= '0;
      bit_q  <= RAD_W'(1) << (2 * (ROOT_W - 1));
    end else if (busy_q) begin
      if ({1'b0, s_q} >= trial) begin
        s_q <= s_q - trial[RAD_W-1:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (bit_q[0]) begin
        busy_q <= 1'b0;
        vld_q  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/srip_cordic.sv */
// ----------------------------------------------------------------------------
// Vectoring CORDIC
// Angle of (den, num) as a fraction of a turn, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srip_cordic (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic signed [srip_pkg::CW-1:0] num_i,
  input  wire logic signed [srip_pkg::CW-1:0] den_i,
  output logic                               vld_o,
  output logic [srip_pkg::ANG_W-1:0]         ang_o
);
  import srip_pkg::*;

  logic signed [CW-1:0] x_q, y_q, dx, dy;
  logic [ANG_W-1:0]     a_q;
  logic [IT_W-1:0]      it_q;
  logic [4:0]           k;
  logic                 busy_q, vld_q;

  assign k     = 5'(it_q);
  assign dx    = y_q >>> k;
  assign dy    = x_q >>> k;
  assign vld_o = vld_q;
  assign ang_o = a_q;

  // Zero input gives angle zero; else pre-rotation into the right half plane, then fixed-count rotations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      vld_q  <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      a_q    <= '0;
      it_q   <= '0;
    end else if (start_i) begin
      it_q <= '0;
      if (num_i == '0 && den_i == '0) begin
        a_q    <= '0;
        busy_q <= 1'b0;
        vld_q  <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        vld_q  <= 1'b0;
        if (den_i < 0) begin
          x_q <= -den_i;
          y_q <= -num_i;
          a_q <= 32'h8000_0000;
        end else begin
          x_q <= den_i;
          y_q <= num_i;
          a_q <= '0;
        end
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        a_q <= a_q + turn_atan(k);
      end else begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        a_q <= a_q - turn_atan(k);
      end
      it_q <= it_q + IT_W'(1);
      if (it_q == IT_W'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
        vld_q  <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/srip_back.sv */
// ----------------------------------------------------------------------------
// Projection engine
// Range, angles and pixel index of a point, the depth store update, and read-and-clear of a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module srip_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [srip_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [srip_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           q_vld_i,
  input  wire srip_pkg::srip_item_t           q_item_i,
  output logic                                q_pop_o,
  output logic                                res_vld_o,
  output srip_pkg::srip_res_t                 res_o,
  input  wire logic                           res_rdy_i,
  output logic                                clr_busy_o
);
  import srip_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SQ, S_SUM, S_START, S_ROOT, S_ANG, S_MAP, S_READ, S_WB
  } state_e;

  localparam int CP_W = ANG_W + COLS_W + 1;
  localparam int RP_W = ANG_W + ROWS_W + 1;

  state_e               state_q;
  srip_item_t           item_q;
  logic [ADDR_W-1:0]    clr_q, addr_q;
  logic [COLS_W-1:0]    cols_q, cols_c;
  logic [ROWS_W-1:0]    rows_q, rows_c;
  logic [SUM_W-1:0]     ax2_q, ay2_q, az2_q, hs_q, s_q;
  logic [RANGE_W-1:0]   range_q, rd_q, mem_wd;
  logic [CP_W-1:0]      colp_q;
  logic [RP_W-1:0]      rowp_q;
  logic                 skip_q, res_vld_q;
  srip_res_t            res_q;
  logic [RANGE_W-1:0]   store_q [MAX_COLS * MAX_ROWS];

  logic [COORD_BITS-1:0] ax, ay, az;
  logic                  start_root, start_az, start_el, mem_we, wb_go;
  logic [ADDR_W-1:0]     mem_addr;
  logic                  r_vld, h_vld, az_vld, el_vld;
  logic [ROOT_W-1:0]     r_root, h_root;
  logic [ROOT_W:0]       r_rem, h_rem;
  logic [ANG_W-1:0]      az_ang, el_ang, azu;
  logic signed [ANG_W:0] el_e;
  logic [ANG_W-1:0]      el_u;
  logic [ROOT_W:0]       r_rnd;
  logic [COLS_W-1:0]     col_p;
  logic [ROWS_W-1:0]     row_p;
  logic                  w_new, w_less;

  // Image size in use, clamped to between one and the store dimensions
  always_comb begin
    cols_c = cols_q;
    if (cols_q == '0) cols_c = COLS_W'(1);
    else if (cols_q > COLS_W'(MAX_COLS)) cols_c = COLS_W'(MAX_COLS);
    rows_c = rows_q;
    if (rows_q == '0) rows_c = ROWS_W'(1);
    else if (rows_q > ROWS_W'(MAX_ROWS)) rows_c = ROWS_W'(MAX_ROWS);
  end

  // Magnitudes of the coordinates
  assign ax = item_q.x[COORD_BITS-1] ? COORD_BITS'(-item_q.x) : COORD_BITS'(item_q.x);
  assign ay = item_q.y[COORD_BITS-1] ? COORD_BITS'(-item_q.y) : COORD_BITS'(item_q.y);
  assign az = item_q.z[COORD_BITS-1] ? COORD_BITS'(-item_q.z) : COORD_BITS'(item_q.z);

  // Root and angle units
  assign start_root = (state_q == S_START) && (s_q != '0);
  assign start_az   = start_root;
  assign start_el   = (state_q == S_ROOT) && h_vld;

  srip_sqrt u_sqrt_range (
    .clk_i, .rst_ni, .start_i(start_root), .rad_i(RAD_W'(s_q)),
    .vld_o(r_vld), .root_o(r_root), .rem_o(r_rem)
  );

  srip_sqrt u_sqrt_horiz (
    .clk_i, .rst_ni, .start_i(start_root), .rad_i(RAD_W'(hs_q) << FRAC_BITS),
    .vld_o(h_vld), .root_o(h_root), .rem_o(h_rem)
  );

  srip_cordic u_cordic_az (
    .clk_i, .rst_ni, .start_i(start_az),
    .num_i(CW'(item_q.x) <<< FRAC_BITS), .den_i(CW'(item_q.z) <<< FRAC_BITS),
    .vld_o(az_vld), .ang_o(az_ang)
  );

  srip_cordic u_cordic_el (
    .clk_i, .rst_ni, .start_i(start_el),
    .num_i(CW'(item_q.y) <<< FRAC_BITS), .den_i($signed({{(CW-ROOT_W){1'b0}}, h_root})),
    .vld_o(el_vld), .ang_o(el_ang)
  );

  // Rounded range and elevation offset into the lower half turn, clamped
  assign r_rnd = (r_rem > {1'b0, r_root}) ? {1'b0, r_root} + 1'b1 : {1'b0, r_root};
  assign azu   = az_ang + 32'h8000_0000;
  assign el_e  = $signed({el_ang[ANG_W-1], el_ang}) + $signed({1'b0, 32'h4000_0000});
  always_comb begin
    if (el_e < 0) el_u = '0;
    else if (el_e > $signed({1'b0, 32'h8000_0000})) el_u = 32'h8000_0000;
    else el_u = el_e[ANG_W-1:0];
  end

  // Rounded pixel indexes before wrap
  assign col_p = COLS_W'(colp_q >> ANG_W);
  assign row_p = ROWS_W'(rowp_q >> (ANG_W - 1));

  // Store update decision
  assign w_new  = (rd_q == '0);
  assign w_less = (range_q < rd_q);
  assign wb_go  = (state_q == S_WB) && (!res_vld_q || res_rdy_i);

  always_comb begin
    mem_we   = 1'b0;
    mem_wd   = '0;
    mem_addr = addr_q;
    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      S_WB: begin
        if (wb_go) begin
          if (item_q.cmd) mem_we = 1'b1;
          else if (!skip_q && (w_new || w_less)) begin
            mem_we = 1'b1;
            mem_wd = range_q;
          end
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  assign q_pop_o    = (state_q == S_IDLE) && q_vld_i;
  assign clr_busy_o = (state_q == S_CLEAR);
  assign res_vld_o  = res_vld_q;
  assign res_o      = res_q;

  // Depth store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) store_q[mem_addr] <= mem_wd;
    rd_q <= store_q[mem_addr];
  end

  // Sequencer, configuration and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      cols_q    <= COLS_W'(1024);
      rows_q    <= ROWS_W'(64);
      res_vld_q <= 1'b0;
      skip_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_IMAGE_COLS) cols_q <= COLS_W'(cfg_data_i);
        if (cfg_idx_i == REG_IMAGE_ROWS) rows_q <= ROWS_W'(cfg_data_i);
      end
      if (res_vld_q && res_rdy_i) res_vld_q <= 1'b0;

      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (q_vld_i) begin
            item_q  <= q_item_i;
            addr_q  <= {q_item_i.rcol, q_item_i.rrow};
            range_q <= '0;
            skip_q  <= 1'b0;
            state_q <= q_item_i.cmd ? S_READ : S_SQ;
          end
        end
        S_SQ: begin
          ax2_q   <= SUM_W'(ax) * SUM_W'(ax);
          ay2_q   <= SUM_W'(ay) * SUM_W'(ay);
          az2_q   <= SUM_W'(az) * SUM_W'(az);
          state_q <= S_SUM;
        end
        S_SUM: begin
          hs_q    <= ax2_q + az2_q;
          s_q     <= ax2_q + az2_q + ay2_q;
          state_q <= S_START;
        end
        S_START: begin
          if (s_q == '0) begin
            skip_q  <= 1'b1;
            state_q <= S_WB;
          end else begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (h_vld) state_q <= S_ANG;
        end
        S_ANG: begin
          if (el_vld && az_vld && r_vld) begin
            range_q <= (r_rnd > (ROOT_W+1)'(RANGE_MAX)) ? RANGE_MAX : RANGE_W'(r_rnd);
            colp_q  <= CP_W'(azu) * CP_W'(cols_c) + CP_W'(33'h0_8000_0000);
            rowp_q  <= RP_W'(el_u) * RP_W'(rows_c) + RP_W'(32'h4000_0000);
            state_q <= S_MAP;
          end
        end
        S_MAP: begin
          addr_q  <= {(col_p >= cols_c) ? COL_W'(0) : COL_W'(col_p),
                      (row_p >= rows_c) ? ROW_W'(0) : ROW_W'(row_p)};
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            res_vld_q          <= 1'b1;
            res_q.col          <= skip_q ? '0 : addr_q[ADDR_W-1:ROW_W];
            res_q.row          <= skip_q ? '0 : addr_q[ROW_W-1:0];
            res_q.range_mm     <= range_q;
            res_q.skipped      <= skip_q;
            res_q.stored       <= !item_q.cmd && !skip_q && (w_new || w_less);
            res_q.newly_filled <= !item_q.cmd && !skip_q && w_new;
            res_q.pixel_range  <= item_q.cmd ? rd_q : '0;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  logic unused_rem;
  assign unused_rem = ^h_rem;

endmodule

`default_nettype wire

/* sv/spherical_range_image_projection.sv */
// An insert of a nonzero point passes a 25-step square root for the horizontal norm, then
// 20 CORDIC rotations for elevation, with squaring, mapping and a store read-modify-write
// around them, to the result register. The engine works on one request at a time.
// A read-and-clear request passes the read and write-back states to the result register.
// After reset the 262144-entry depth store is swept to zero, one entry a cycle,
// while no request is accepted; configuration writes are taken throughout. Reset restores 1024x64.
`default_nettype none
`include "spherical_range_image_projection_assert.svh"

// ----------------------------------------------------------------------------
// Spherical range image projection
// Projects points into a spherical range image kept in an on-chip depth store.
// ----------------------------------------------------------------------------
module spherical_range_image_projection (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [srip_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [srip_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y, point_z, read_col, read_row, zero fill
  input  wire logic [79:0]                    s_axis_tdata,
  // command
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // col, row, range_mm, stored, newly_filled, skipped, pixel_range, zero fill
  output logic [63:0]                         m_axis_tdata
);
  import srip_pkg::*;

  srip_item_t in_item, q_item;
  srip_res_t  res;
  logic       q_vld, q_pop, clr_busy;

  // Unpack the request
  assign in_item.cmd  = s_axis_tuser;
  assign in_item.x    = s_axis_tdata[19:0];
  assign in_item.y    = s_axis_tdata[39:20];
  assign in_item.z    = s_axis_tdata[59:40];
  assign in_item.rcol = s_axis_tdata[69:60];
  assign in_item.rrow = s_axis_tdata[77:70];

  srip_front u_front (
    .clk_i, .rst_ni, .hold_i(clr_busy),
    .in_vld_i(s_axis_tvalid), .in_rdy_o(s_axis_tready), .in_item_i(in_item),
    .q_vld_o(q_vld), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  srip_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_vld_i(q_vld), .q_item_i(q_item), .q_pop_o(q_pop),
    .res_vld_o(m_axis_tvalid), .res_o(res), .res_rdy_i(m_axis_tready),
    .clr_busy_o(clr_busy)
  );

  // Pack the result
  assign m_axis_tdata = {3'b000, res};

  // No request enters while the store is being cleared.
  `SRIP_ASSERT_IMPL(a_no_accept_in_clear, clr_busy, !s_axis_tready, "request taken during clear")
  // A skipped point never touches the store.
  `SRIP_ASSERT_IMPL(a_skip_no_store, m_axis_tvalid && res.skipped,
                    !res.stored && !res.newly_filled, "skipped point stored")
  // A newly filled pixel is always a stored one.
  `SRIP_ASSERT_IMPL(a_new_is_stored, m_axis_tvalid && res.newly_filled, res.stored,
                    "fill without store")
  // The clearing sweep runs once after reset and never restarts.
  `SRIP_ASSERT_NEXT(a_clear_once, !clr_busy, !clr_busy, "clearing restarted")

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Spherical range image projection testbench
// Drives insert and read-and-clear requests through the stream ports, predicts
// every result with a local projection model and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import srip_pkg::*;

  localparam int WATCHDOG = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  spherical_range_image_projection dut (.*);

  always #2 clk_i = ~clk_i;

  // Predictor state: pixel ranges, image size, expected results
  logic [19:0] pixel_mirror [MAX_COLS*MAX_ROWS];
  int unsigned cur_cols, cur_rows;
  srip_res_t   pending_results [$];
  int          send_idle_pct, recv_idle_pct;
  int          hold_off_cycles;
  int          mismatches, received, sent, idle_cycles;
  bit          timed_out;

  function automatic longint fshift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((((-v) - 1) >>> s)) - 1;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC angle as a fraction of a turn
  function automatic logic [31:0] cordic_angle(longint num, longint den);
    longint vx, vy, dx, dy;
    logic [31:0] a;
    if (num == 0 && den == 0) return '0;
    vx = den;
    vy = num;
    a = '0;
    if (den < 0) begin
      vx = -den;
      vy = -num;
      a = 32'h80000000;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(vy, i);
      dy = fshift(vx, i);
      if (vy > 0) begin
        vx += dx; vy -= dy; a += turn_atan(i[4:0]);
      end else begin
        vx -= dx; vy += dy; a -= turn_atan(i[4:0]);
      end
    end
    return a;
  endfunction

  function automatic srip_res_t project_request(srip_item_t it);
    srip_res_t res;
    longint x, y, z, h, e;
    longint unsigned hs, s, r, cols, rows, c, rw;
    logic [31:0] azu, elu;
    int addr;
    res = '0;
    if (it.cmd) begin
      res.col = it.rcol;
      res.row = it.rrow;
      addr = int'(it.rcol) * MAX_ROWS + int'(it.rrow);
      res.pixel_range = pixel_mirror[addr];
      pixel_mirror[addr] = '0;
      return res;
    end
    x = it.x; y = it.y; z = it.z;
    hs = x * x + z * z;
    s = hs + y * y;
    if (s == 0) begin
      res.skipped = 1'b1;
      return res;
    end
    r = isqrt(s);
    if (s - r * r > r) r++;
    if (r > RANGE_MAX) r = RANGE_MAX;
    cols = (cur_cols < 1) ? 1 : (cur_cols > MAX_COLS ? MAX_COLS : cur_cols);
    rows = (cur_rows < 1) ? 1 : (cur_rows > MAX_ROWS ? MAX_ROWS : cur_rows);
    azu = cordic_angle(x <<< FRAC_BITS, z <<< FRAC_BITS) + 32'h80000000;
    c = (longint'(azu) * cols + 64'h80000000) >> 32;
    if (c >= cols) c = 0;
    h = isqrt(hs << FRAC_BITS);
    elu = cordic_angle(y <<< FRAC_BITS, h);
    e = longint'($signed(elu)) + 64'h40000000;
    if (e < 0) e = 0;
    if (e > 64'h80000000) e = 64'h80000000;
    rw = (longint'(e) * rows + 64'h40000000) >> 31;
    if (rw >= rows) rw = 0;
    res.col = c[COL_W-1:0];
    res.row = rw[ROW_W-1:0];
    res.range_mm = r[19:0];
    addr = int'(c) * MAX_ROWS + int'(rw);
    if (pixel_mirror[addr] == 0) begin
      pixel_mirror[addr] = r[19:0];
      res.stored = 1'b1;
      res.newly_filled = 1'b1;
    end else if (r[19:0] < pixel_mirror[addr]) begin
      pixel_mirror[addr] = r[19:0];
      res.stored = 1'b1;
    end
    return res;
  endfunction

  // Send one request, idling at random first
  task automatic send_request(srip_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {2'b0, it.rrow, it.rcol, it.z, it.y, it.x};
    pending_results = {pending_results, project_request(it)};
    sent++;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic insert_point(int px, int py, int pz);
    srip_item_t it;
    it = '0;
    it.x = COORD_BITS'(px); it.y = COORD_BITS'(py); it.z = COORD_BITS'(pz);
    send_request(it);
  endtask

  task automatic read_pixel(int c, int r);
    srip_item_t it;
    it = '0;
    it.cmd = 1'b1;
    it.rcol = COL_W'(c); it.rrow = ROW_W'(r);
    send_request(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && !timed_out) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // Register write while the block is idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_IMAGE_COLS) cur_cols = val & 11'h7FF;
    else cur_rows = val & 9'h1FF;
  endtask

  function automatic int rand_coord();
    case ($urandom_range(3))
      0: return $signed($urandom_range(20'hFFFFF) << 12) >>> 12;
      1: return int'($urandom_range(200)) - 100;
      2: return ($urandom_range(1)) ? 524287 : -524288;
      default: return int'($urandom_range(40000)) - 20000;
    endcase
  endfunction

  // Random mix: points near and far, reads of recent pixels, some wide reads
  task automatic random_requests(int n);
    srip_res_t last;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(1) && pending_results.size() != 0) begin
          last = pending_results[$];
          read_pixel(last.col, last.row);
        end else begin
          read_pixel($urandom_range(1023), $urandom_range(255));
        end
      end else begin
        insert_point(rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  task automatic test_directed();
    insert_point(0, 0, 0);
    insert_point(0, 1000, 0);
    insert_point(0, -1000, 0);
    insert_point(-524288, -524288, -524288);
    insert_point(524287, 524287, 524287);
    insert_point(524287, -524288, 0);
    insert_point(0, 0, -5000);
    insert_point(0, 0, 5000);
    insert_point(0, 0, 4000);
    insert_point(0, 0, 6000);
    insert_point(-1, 0, -5000);
    insert_point(1, 0, -5000);
    insert_point(3, 4, 0);
    read_pixel(512, 32);
    read_pixel(512, 32);
    read_pixel(1023, 255);
    read_pixel(0, 0);
  endtask

  task automatic test_image_sizes();
    write_reg(REG_IMAGE_COLS, 1);
    write_reg(REG_IMAGE_ROWS, 1);
    random_requests(80);
    write_reg(REG_IMAGE_COLS, 0);
    write_reg(REG_IMAGE_ROWS, 0);
    random_requests(40);
    write_reg(REG_IMAGE_COLS, 2047);
    write_reg(REG_IMAGE_ROWS, 511);
    random_requests(80);
    write_reg(REG_IMAGE_COLS, 360);
    write_reg(REG_IMAGE_ROWS, 256);
    random_requests(80);
    write_reg(REG_IMAGE_COLS, 1024);
    write_reg(REG_IMAGE_ROWS, 64);
  endtask

  task automatic test_idle_patterns();
    send_idle_pct = 16; recv_idle_pct = 63;
    random_requests(350);
    send_idle_pct = 63; recv_idle_pct = 16;
    random_requests(350);
    send_idle_pct = 0; recv_idle_pct = 0;
    random_requests(300);
  endtask

  // Receiver holds off while requests keep arriving
  task automatic test_backpressure();
    hold_off_cycles = 3000;
    random_requests(40);
  endtask

  // Result checker and receiver idling
  always @(posedge clk_i) begin
    srip_res_t got, want;
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(srip_res_t)-1:0];
      received++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.col != want.col || got.row != want.row ||
            got.range_mm != want.range_mm || got.stored != want.stored ||
            got.newly_filled != want.newly_filled || got.skipped != want.skipped ||
            got.pixel_range != want.pixel_range) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h, got %h", want, got);
        end
      end
    end
  end

  // Watchdog on cycles without any request or result moving
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        hold_off_cycles > 0) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG && !timed_out) begin
        timed_out = 1'b1;
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin
    cur_cols = 1024; cur_rows = 64;
    mismatches = 0; received = 0; sent = 0; idle_cycles = 0;
    hold_off_cycles = 0; timed_out = 1'b0;
    send_idle_pct = 0; recv_idle_pct = 0;
    foreach (pixel_mirror[i]) pixel_mirror[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_image_sizes();
    test_backpressure();
    test_idle_patterns();
    drain();
    if (pending_results.size() != 0) mismatches++;
    $display("Sent %0d requests, %0d results checked, over several image sizes", sent, received);
    $display("and three idling patterns with one long receiver stall.");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
